// ===== sv/rspe_pkg.sv =====
// ----------------------------------------------------------------------------
// rspe_pkg
// Shared constants, types and GF(256) arithmetic for the Reed-Solomon parity
// encoder (field polynomial 0x11D).
// ----------------------------------------------------------------------------
`default_nettype none

package rspe_pkg;

	localparam int MAX_PARITY = 32;
	localparam int CFG_W      = 6;
	localparam int CNT_W      = $clog2(MAX_PARITY + 1);
	localparam int BYTE_W     = 8;

	localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(10);
	localparam logic [BYTE_W:0]   GF_POLY   = 9'h11D;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		logic step;
		logic last;
		logic gen_clr;
		logic gen_step;
		logic out_shift;
	} rspe_ctl_t;

	function automatic byte_t gf_mul(input byte_t x, input byte_t y);
		logic [BYTE_W:0] a;
		byte_t           r;
		a = {1'b0, x};
		r = '0;
		for (int i = 0; i < BYTE_W; i++) begin
			if (y[i])
				r = r ^ a[BYTE_W-1:0];
			a = {a[BYTE_W-1:0], 1'b0};
			if (a[BYTE_W])
				a = a ^ GF_POLY;
		end
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] c);
		if (c == '0)
			return CNT_W'(1);
		else if (int'(c) > MAX_PARITY)
			return CNT_W'(MAX_PARITY);
		else
			return CNT_W'(c);
	endfunction

endpackage

`default_nettype wire

// ===== sv/rspe_cell.sv =====
// ----------------------------------------------------------------------------
// rspe_cell
// One parity cell: LFSR byte, generator coefficient and output buffer byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rspe_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rspe_pkg::rspe_ctl_t ctl,
	input  wire rspe_pkg::byte_t     fb,
	input  wire rspe_pkg::byte_t     root,
	input  wire rspe_pkg::byte_t     store_up,
	input  wire rspe_pkg::byte_t     coef_dn,
	input  wire rspe_pkg::byte_t     obuf_up,
	output rspe_pkg::byte_t          store,
	output rspe_pkg::byte_t          coef,
	output rspe_pkg::byte_t          obuf
);
	import rspe_pkg::*;

	byte_t store_q;
	byte_t coef_q;
	byte_t obuf_q;
	byte_t store_nxt;

	assign store_nxt = store_up ^ gf_mul(coef_q, fb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
		end else if (ctl.step) begin
			store_q <= ctl.last ? '0 : store_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.gen_clr)
			coef_q <= '0;
		else if (ctl.gen_step)
			coef_q <= coef_q ^ gf_mul(root, coef_dn);
	end

	// load on a last request wins over draining
	always_ff @(posedge clk) begin
		if (ctl.step && ctl.last)
			obuf_q <= store_nxt;
		else if (ctl.out_shift)
			obuf_q <= obuf_up;
	end

	assign store = store_q;
	assign coef  = coef_q;
	assign obuf  = obuf_q;

endmodule

`default_nettype wire

// ===== sv/reed_solomon_parity_encoder.sv =====
// ----------------------------------------------------------------------------
// reed_solomon_parity_encoder
// Systematic RS parity encoder over GF(256), poly 0x11D, roots a^0..a^(ec-1).
// ----------------------------------------------------------------------------
// channel  dir  tdata           tuser  tlast
// s_*      in   data_byte[7:0]  -      last_byte
// m_*      out  parity_byte[7:0] -     last_parity
// cfg_*    in   parity_count[5:0] on cfg_wdata, written when cfg_we is high
//
// One data byte per cycle; the last byte of a block loads the ec parity bytes
// into an output row that drains one per cycle while m_tready is high, so the
// next block streams in meanwhile. Outside a rebuild, a last byte stalls only
// while the previous parity is not drained. A generator rebuild after reset or
// a count change holds s_tready low; the coefficient chain steps once a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module reed_solomon_parity_encoder (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [7:0]                 s_tdata,   // [7:0] data_byte
	input  wire logic                       s_tlast,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [7:0]                      m_tdata,   // [7:0] parity_byte
	output logic                            m_tlast,
	input  wire logic                       cfg_we,
	input  wire logic [rspe_pkg::CFG_W-1:0] cfg_wdata
);
	import rspe_pkg::*;

	byte_t            store_w [MAX_PARITY];
	byte_t            coef_w  [MAX_PARITY];
	byte_t            obuf_w  [MAX_PARITY];
	byte_t            fb;
	byte_t            root_q;
	rspe_ctl_t        ctl;
	logic [CFG_W-1:0] count_q;
	logic [CNT_W-1:0] active_q;
	logic [CNT_W-1:0] steps_q;
	logic [CNT_W-1:0] rem_q;
	logic             start_q;
	logic             pending_q;
	logic             in_block_q;
	logic             s_acc;
	logic             m_acc;
	logic             gen_busy;
	logic             out_free;

	assign s_acc    = s_tvalid & s_tready;
	assign m_acc    = m_tvalid & m_tready;
	assign gen_busy = start_q | (steps_q != '0);
	assign out_free = (rem_q == '0) | (m_acc & m_tlast);
	assign s_tready = ~gen_busy & (~s_tlast | out_free);
	assign fb       = s_tdata ^ store_w[0];

	assign m_tvalid = (rem_q != '0);
	assign m_tdata  = obuf_w[0];
	assign m_tlast  = (rem_q == CNT_W'(1));

	always_comb begin
		ctl.step      = s_acc;
		ctl.last      = s_tlast;
		ctl.gen_clr   = start_q;
		ctl.gen_step  = ~start_q & (steps_q != '0);
		ctl.out_shift = m_acc;
	end

	for (genvar i = 0; i < MAX_PARITY; i++) begin : g_cell
		byte_t store_up;
		byte_t coef_dn;
		byte_t obuf_up;
		if (i == MAX_PARITY - 1) begin : g_top
			assign store_up = '0;
			assign obuf_up  = '0;
		end else begin : g_mid
			assign store_up = store_w[i+1];
			assign obuf_up  = obuf_w[i+1];
		end
		if (i == 0) begin : g_bot
			assign coef_dn = byte_t'(1);
		end else begin : g_up
			assign coef_dn = coef_w[i-1];
		end
		rspe_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.fb       (fb),
			.root     (root_q),
			.store_up (store_up),
			.coef_dn  (coef_dn),
			.obuf_up  (obuf_up),
			.store    (store_w[i]),
			.coef     (coef_w[i]),
			.obuf     (obuf_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= CFG_RESET;
			active_q   <= clamp_count(CFG_RESET);
			steps_q    <= '0;
			root_q     <= byte_t'(1);
			start_q    <= 1'b1;
			pending_q  <= 1'b0;
			in_block_q <= 1'b0;
			rem_q      <= '0;
		end else begin
			if (start_q) begin
				start_q  <= 1'b0;
				active_q <= clamp_count(count_q);
				steps_q  <= clamp_count(count_q);
				root_q   <= byte_t'(1);
			end else if (steps_q != '0) begin
				steps_q <= steps_q - CNT_W'(1);
				root_q  <= gf_mul(root_q, byte_t'(2));
			end

			if (s_acc) begin
				in_block_q <= ~s_tlast;
				if (s_tlast && pending_q) begin
					start_q   <= 1'b1;
					pending_q <= 1'b0;
				end
			end

			// defer the rebuild to the end of an open block
			if (cfg_we) begin
				count_q <= cfg_wdata;
				if (in_block_q)
					pending_q <= 1'b1;
				else
					start_q <= 1'b1;
			end

			if (s_acc && s_tlast)
				rem_q <= active_q;
			else if (m_acc)
				rem_q <= rem_q - CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

// ===== sv/rspe_checker.sv =====
// ----------------------------------------------------------------------------
// rspe_checker
// Port-level checks of the parity encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rspe_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic s_tlast,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("parity request changed while stalled");

	a_last_gives_parity: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> m_tvalid)
		else $error("no parity after last data byte");

	a_block_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast && !(s_tvalid && s_tready && s_tlast)
		|=> !m_tvalid)
		else $error("parity continues past final byte");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tlast && m_tvalid && !(m_tready && m_tlast) |-> !s_tready)
		else $error("last byte taken while parity still pending");

endmodule

bind reed_solomon_parity_encoder rspe_checker u_rspe_checker (.*);

`default_nettype wire

// ===== dv/reed_solomon_parity_encoder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reed_solomon_parity_encoder_test
// Streams data blocks into the RS(GF256, 0x11D) parity encoder under several
// parity counts and handshake pressure levels. Every parity request leaving
// the block is checked against an in-bench LFSR encoder model, or against a
// typed-in value for the directed rows whose parity is obvious.
// ----------------------------------------------------------------------------
`default_nettype none

module reed_solomon_parity_encoder_test;

	localparam int MAXP          = rspe_pkg::MAX_PARITY;
	localparam int CW            = rspe_pkg::CFG_W;
	localparam int DIRECTED_ROWS = 19;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 50;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 40;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int GAP_NONE      = 0;
	localparam int GAP_HEAVY     = 64;
	localparam int GAP_MIXED     = 34;

	typedef struct packed {
		logic [CW-1:0] count;
		logic [7:0]    data;
		logic          is_last;
		logic          typed;
		logic [7:0]    typed_val;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] value;
		logic       tail;
	} parity_exp_t;

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [7:0]    s_tdata;   // [7:0] data_byte
	logic          s_tlast;
	logic          m_tvalid;
	logic          m_tready;
	logic [7:0]    m_tdata;   // [7:0] parity_byte
	logic          m_tlast;
	logic          cfg_we;
	logic [CW-1:0] cfg_wdata;

	logic [7:0]    lfsr_bytes [MAXP];
	logic [7:0]    gen_coef [MAXP];
	logic [CW-1:0] reg_count;
	logic [CW-1:0] cur_count;
	int            live_count;
	bit            mid_block;

	parity_exp_t   parity_due [$];
	parity_exp_t   want;
	stim_row_t     directed_rows [DIRECTED_ROWS];

	int            send_gap_pct;
	int            recv_stall_pct;
	int            fault_count;
	int            requests_sent;
	int            blocks_sent;
	int            parity_checked;
	int            count_writes;
	int unsigned   cycle_count;

	reed_solomon_parity_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		for (int k = 7; k >= 0; k--) begin
			acc = {acc[6:0], 1'b0} ^ (acc[7] ? 8'h1D : 8'h00);
			if (b[k])
				acc = acc ^ a;
		end
		return acc;
	endfunction

	function automatic void rebuild_generator();
		logic [7:0] poly [MAXP + 1];
		logic [7:0] root;
		if (reg_count == 0)
			live_count = 1;
		else if (int'(reg_count) > MAXP)
			live_count = MAXP;
		else
			live_count = int'(reg_count);
		for (int i = 0; i <= MAXP; i++)
			poly[i] = 8'h00;
		poly[0] = 8'h01;
		root = 8'h01;
		for (int i = 0; i < live_count; i++) begin
			poly[i + 1] = 8'h00;
			for (int j = i + 1; j > 0; j--)
				poly[j] = poly[j - 1] ^ gf_times(poly[j], root);
			poly[0] = gf_times(poly[0], root);
			root = gf_times(root, 8'h02);
		end
		for (int i = 0; i < MAXP; i++)
			gen_coef[i] = (i < live_count) ? poly[i] : 8'h00;
	endfunction

	function automatic void set_count(input logic [CW-1:0] v);
		reg_count = v;
		if (!mid_block)
			rebuild_generator();
	endfunction

	function automatic void encode_byte(input logic [7:0] d, input logic is_last,
			input logic typed, input logic [7:0] typed_val);
		logic [7:0] fb;
		fb = d ^ lfsr_bytes[0];
		for (int j = 0; j + 1 < live_count; j++)
			lfsr_bytes[j] = lfsr_bytes[j + 1];
		lfsr_bytes[live_count - 1] = 8'h00;
		for (int j = 0; j < live_count; j++)
			lfsr_bytes[j] = lfsr_bytes[j] ^ gf_times(gen_coef[live_count - 1 - j], fb);
		if (!is_last) begin
			mid_block = 1'b1;
			return;
		end
		for (int j = 0; j < live_count; j++)
			parity_due.push_back('{typed ? typed_val : lfsr_bytes[j], j == live_count - 1});
		for (int j = 0; j < MAXP; j++)
			lfsr_bytes[j] = 8'h00;
		mid_block = 1'b0;
		blocks_sent++;
		rebuild_generator();
	endfunction

	task automatic push_byte(input logic [7:0] d, input logic is_last,
			input logic typed, input logic [7:0] typed_val);
		@(negedge clk);
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tlast  <= is_last;
		do
			@(posedge clk);
		while (!s_tready);
		encode_byte(d, is_last, typed, typed_val);
		requests_sent++;
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (parity_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_count(input logic [CW-1:0] v);
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		set_count(v);
		cur_count = v;
		count_writes++;
	endtask

	always @(negedge clk)
		m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (parity_due.size() == 0) begin
				$display("%0t: unexpected parity request: expected none, actual %02h last %0b",
					$time, m_tdata, m_tlast);
				fault_count++;
			end else begin
				want = parity_due.pop_front();
				if (m_tdata !== want.value) begin
					$display("%0t: parity_byte mismatch: expected %02h, actual %02h",
						$time, want.value, m_tdata);
					fault_count++;
				end
				if (m_tlast !== want.tail) begin
					$display("%0t: last_parity mismatch: expected %0b, actual %0b",
						$time, want.tail, m_tlast);
					fault_count++;
				end
				parity_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d parity bytes outstanding",
				cycle_count, parity_due.size());
			$display("reed_solomon_parity_encoder test failed");
			$finish;
		end
	end

	initial begin
		int        sent;
		int        len;
		bit        paused;
		stim_row_t row;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = 8'h00;
		s_tlast        = 1'b0;
		m_tready       = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		send_gap_pct   = GAP_NONE;
		recv_stall_pct = GAP_NONE;
		fault_count    = 0;
		requests_sent  = 0;
		blocks_sent    = 0;
		parity_checked = 0;
		count_writes   = 0;
		cycle_count    = 0;
		mid_block      = 1'b0;
		for (int j = 0; j < MAXP; j++)
			lfsr_bytes[j] = 8'h00;
		reg_count = rspe_pkg::CFG_RESET;
		cur_count = rspe_pkg::CFG_RESET;
		rebuild_generator();

		directed_rows = '{
			// zero byte right after reset: all ten parity bytes zero
			'{6'd10, 8'h00, 1'b1, 1'b1, 8'h00},
			'{6'd10, 8'hFF, 1'b1, 1'b0, 8'h00},
			'{6'd10, 8'h01, 1'b0, 1'b0, 8'h00},
			'{6'd10, 8'h80, 1'b0, 1'b0, 8'h00},
			'{6'd10, 8'h55, 1'b1, 1'b0, 8'h00},
			// one parity byte: XOR of the block
			'{6'd1,  8'hA5, 1'b0, 1'b0, 8'h00},
			'{6'd1,  8'h5A, 1'b1, 1'b1, 8'hFF},
			// zero count acts as one
			'{6'd0,  8'h12, 1'b0, 1'b0, 8'h00},
			'{6'd0,  8'h34, 1'b1, 1'b1, 8'h26},
			'{6'd32, 8'hFF, 1'b0, 1'b0, 8'h00},
			'{6'd32, 8'h00, 1'b0, 1'b0, 8'h00},
			'{6'd32, 8'hFF, 1'b1, 1'b0, 8'h00},
			// count above the maximum acts as the maximum
			'{6'd63, 8'h00, 1'b0, 1'b0, 8'h00},
			'{6'd63, 8'h00, 1'b1, 1'b1, 8'h00},
			'{6'd33, 8'h7E, 1'b1, 1'b0, 8'h00},
			'{6'd2,  8'h01, 1'b1, 1'b0, 8'h00},
			'{6'd2,  8'hFE, 1'b1, 1'b0, 8'h00},
			'{6'd10, 8'hC3, 1'b0, 1'b0, 8'h00},
			'{6'd10, 8'h3C, 1'b1, 1'b0, 8'h00}
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			row = directed_rows[i];
			if (row.count != cur_count)
				write_count(row.count);
			push_byte(row.data, row.is_last, row.typed, row.typed_val);
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       write_count(CW'(1));
				1:       write_count(CW'(32));
				2:       write_count(CW'(0));
				3:       write_count(CW'(63));
				4:       write_count(CW'(7));
				5:       write_count(CW'(10));
				6:       write_count(CW'(33));
				default: write_count(CW'($urandom_range(63)));
			endcase
			case (p % 4)
				0: begin
					send_gap_pct   = GAP_NONE;
					recv_stall_pct = GAP_NONE;
				end
				1: begin
					send_gap_pct   = GAP_HEAVY;
					recv_stall_pct = GAP_NONE;
				end
				2: begin
					send_gap_pct   = GAP_NONE;
					recv_stall_pct = GAP_HEAVY;
				end
				default: begin
					send_gap_pct   = GAP_MIXED;
					recv_stall_pct = GAP_MIXED;
				end
			endcase
			sent   = 0;
			paused = 1'b0;
			while (sent < PHASE_ITEMS) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(6, 1);
				if (len > PHASE_ITEMS - sent)
					len = PHASE_ITEMS - sent;
				for (int k = 0; k < len; k++)
					push_byte(8'($urandom_range(255)), k == len - 1, 1'b0, 8'h00);
				sent += len;
				if (!paused && sent >= PHASE_ITEMS / 2) begin
					hold_until_drained();
					paused = 1'b1;
				end
			end
		end

		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d data requests in %0d blocks across %0d parity-count writes",
			requests_sent, blocks_sent, count_writes);
		$display("checked %0d parity requests, %0d mismatches", parity_checked, fault_count);
		if (fault_count == 0 && parity_due.size() == 0)
			$display("reed_solomon_parity_encoder test passed");
		else
			$display("reed_solomon_parity_encoder test failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
sv/rspe_pkg.sv
sv/rspe_cell.sv
sv/reed_solomon_parity_encoder.sv
sv/rspe_checker.sv
dv/reed_solomon_parity_encoder_test.sv
